### hw/rtl/sss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted set statistics package
// Shared widths, word types, back-end states and divider interface types.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int unsigned VAL_W       = 8;
  localparam int unsigned CNT_W       = 7;
  localparam int unsigned SUM_W       = 14;
  localparam int unsigned MAX_ITEMS   = 64;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [VAL_W-1:0] value_in;
    logic             last_in;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] sorted_value;
    logic             last_out;
    logic [VAL_W-1:0] minimum;
    logic [VAL_W-1:0] maximum;
    logic [VAL_W-1:0] average;
    logic [VAL_W-1:0] middle_value;
  } out_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             set_end;
  } queue_entry_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEEK,
    ST_STATS,
    ST_EMIT
  } back_state_e;

endpackage

`default_nettype wire

### hw/rtl/sorted_set_statistics_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted set statistics
// Collects a set of bytes and returns it in descending order with the set's
// minimum, maximum, truncated mean and median on every word.
//
// Input words carry a byte and a last flag. The word with the last flag, or
// the word that fills the MaxItems store, ends the set. Input is taken one
// word per cycle while the queue has room; the queue drains into the
// insertion sorter at one word per cycle while the back end is loading.
// After the ending word reaches the sorter, one pass over the n held values
// picks out the median, the mean comes from a serial divider running
// alongside, and then the n sorted words leave one per cycle while the
// receiver does not stall. The front end keeps taking words for the next set
// into the queue meanwhile.
// Output words sit in a register; while the receiver stalls, the word holds
// and emission pauses. Reset empties the queue, the sorter and the output.
// ----------------------------------------------------------------------------
module sorted_set_statistics_top #(
  parameter int unsigned MaxItems   = sss_pkg::MAX_ITEMS,
  parameter int unsigned QueueDepth = sss_pkg::QUEUE_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  input  wire sss_pkg::in_word_t  in_word_i,
  output logic                    in_stall_o,
  output logic                    out_valid_o,
  output sss_pkg::out_word_t      out_word_o,
  input  wire logic               out_stall_i
);

  sss_pkg::queue_entry_t push_data, pop_data;
  sss_pkg::div_req_t     div_req;
  sss_pkg::div_rsp_t     div_rsp;
  logic push, pop, full, empty;

  sss_front #(
    .MaxItems (MaxItems)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_word_i   (in_word_i),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  sss_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .full_o      (full),
    .empty_o     (empty)
  );

  sss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  sss_back #(
    .MaxItems (MaxItems)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_data_i  (pop_data),
    .empty_i     (empty),
    .pop_o       (pop),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

  a_min_le_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.minimum <= out_word_o.maximum))
    else $error("minimum above maximum");

  a_value_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.sorted_value >= out_word_o.minimum &&
                     out_word_o.sorted_value <= out_word_o.maximum))
    else $error("sorted value outside the set range");

  a_median_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.middle_value >= out_word_o.minimum &&
                     out_word_o.middle_value <= out_word_o.maximum))
    else $error("median outside the set range");

  a_emit_unbroken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_word_o.last_out) |=> out_valid_o)
    else $error("gap inside an emitted set");

endmodule

`default_nettype wire

### hw/rtl/sss_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted set statistics front end
// Accepts input words, tracks the set length and marks the word that ends
// a set, either by its last flag or because the store is full.
// ----------------------------------------------------------------------------
module sss_front #(
  parameter int unsigned MaxItems = sss_pkg::MAX_ITEMS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire sss_pkg::in_word_t     in_word_i,
  output logic                       in_stall_o,
  output logic                       push_o,
  output sss_pkg::queue_entry_t      push_data_o,
  input  wire logic                  full_i
);

  localparam int unsigned CntW = $clog2(MaxItems + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            set_end;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;
  assign set_end    = in_word_i.last_in || (cnt_q == CntW'(MaxItems - 1));

  assign push_data_o.value   = in_word_i.value_in;
  assign push_data_o.set_end = set_end;

  always_comb begin
    cnt_d = cnt_q;
    if (push_o) begin
      cnt_d = set_end ? '0 : cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sss_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted set statistics queue
// Small first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module sss_queue #(
  parameter int unsigned Depth = sss_pkg::QUEUE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire sss_pkg::queue_entry_t push_data_i,
  input  wire logic                  pop_i,
  output sss_pkg::queue_entry_t      pop_data_o,
  output logic                       full_o,
  output logic                       empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned LvlW = $clog2(Depth + 1);

  sss_pkg::queue_entry_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic            do_push, do_pop;

  assign full_o     = (lvl_q == LvlW'(Depth));
  assign empty_o    = (lvl_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    lvl_d = lvl_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      lvl_d = lvl_q + LvlW'(1);
    end else if (do_pop && !do_push) begin
      lvl_d = lvl_q - LvlW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sss_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted set statistics divider
// Restoring divider, one quotient bit per cycle, for the set mean.
// ----------------------------------------------------------------------------
module sss_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sss_pkg::div_req_t req_i,
  output sss_pkg::div_rsp_t      rsp_o
);

  localparam int unsigned SumW  = sss_pkg::SUM_W;
  localparam int unsigned CntW  = sss_pkg::CNT_W;
  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]  quo_q, quo_d;
  logic [CntW-1:0]  rem_q, rem_d;
  logic [CntW-1:0]  dvs_q, dvs_d;
  logic [StepW-1:0] step_q, step_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW:0]    rem_sh;
  logic [CntW:0]    diff;
  logic             ge;

  assign rem_sh = {rem_q, quo_q[SumW-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_q});
  assign diff   = rem_sh - {1'b0, dvs_q};

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[sss_pkg::VAL_W-1:0];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      step_d = StepW'(SumW);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      quo_d  = {quo_q[SumW-2:0], ge};
      rem_d  = ge ? diff[CntW-1:0] : rem_sh[CntW-1:0];
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/sss_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Sorted set statistics back end
// Insertion sorter cells, running statistics, median pass and output stage.
// ----------------------------------------------------------------------------
module sss_back #(
  parameter int unsigned MaxItems = sss_pkg::MAX_ITEMS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire sss_pkg::queue_entry_t pop_data_i,
  input  wire logic                  empty_i,
  output logic                       pop_o,
  output sss_pkg::div_req_t          div_req_o,
  input  wire sss_pkg::div_rsp_t     div_rsp_i,
  output logic                       out_valid_o,
  output sss_pkg::out_word_t         out_word_o,
  input  wire logic                  out_stall_i
);

  localparam int unsigned CntW = $clog2(MaxItems + 1);
  localparam int unsigned ValW = sss_pkg::VAL_W;
  localparam int unsigned SumW = sss_pkg::SUM_W;

  logic [ValW-1:0] cell_q [MaxItems];
  logic [ValW-1:0] cell_d [MaxItems];
  logic [MaxItems-1:0] gt;

  sss_pkg::back_state_e state_q, state_d;
  logic [CntW-1:0] n_q, n_d, k_q, k_d, half, n_new;
  logic [SumW-1:0] sum_q, sum_d, sum_new;
  logic [ValW-1:0] min_q, min_d, max_q, max_d;
  logic [ValW-1:0] mid_hi_q, mid_hi_d, mid_lo_q, mid_lo_d;
  logic [ValW-1:0] avg_q, avg_d, med_q, med_d;
  logic [ValW:0]   mid_sum;
  sss_pkg::out_word_t out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic            do_insert, do_rotate, out_free, k_last;
  logic [ValW-1:0] v;

  assign v        = pop_data_i.value;
  assign half     = n_q >> 1;
  assign n_new    = n_q + CntW'(1);
  assign sum_new  = sum_q + SumW'(v);
  assign mid_sum  = {1'b0, mid_hi_q} + {1'b0, mid_lo_q};
  assign out_free = !out_valid_q || !out_stall_i;
  assign k_last   = (k_q + CntW'(1) == n_q);

  assign pop_o     = (state_q == sss_pkg::ST_LOAD) && !empty_i;
  assign do_insert = pop_o;
  assign do_rotate = (state_q == sss_pkg::ST_SEEK) ||
                     ((state_q == sss_pkg::ST_EMIT) && out_free);

  assign div_req_o.start    = do_insert && pop_data_i.set_end;
  assign div_req_o.dividend = sum_new;
  assign div_req_o.divisor  = sss_pkg::CNT_W'(n_new);

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    for (int i = 0; i < MaxItems; i++) begin
      gt[i] = (CntW'(i) >= n_q) || (v > cell_q[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < MaxItems; i++) begin
      cell_d[i] = cell_q[i];
    end
    if (do_insert) begin
      cell_d[0] = gt[0] ? v : cell_q[0];
      for (int i = 1; i < MaxItems; i++) begin
        if (gt[i]) begin
          cell_d[i] = gt[i-1] ? cell_q[i-1] : v;
        end
      end
    end else if (do_rotate) begin
      for (int i = 0; i < MaxItems - 1; i++) begin
        cell_d[i] = (CntW'(i + 1) == n_q) ? cell_q[0] : cell_q[i+1];
      end
      cell_d[MaxItems-1] = cell_q[0];
    end
  end

  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    k_d         = k_q;
    sum_d       = sum_q;
    min_d       = min_q;
    max_d       = max_q;
    mid_hi_d    = mid_hi_q;
    mid_lo_d    = mid_lo_q;
    avg_d       = avg_q;
    med_d       = med_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      sss_pkg::ST_LOAD: begin
        if (do_insert) begin
          n_d   = n_new;
          sum_d = sum_new;
          min_d = (n_q == '0 || v < min_q) ? v : min_q;
          max_d = (n_q == '0 || v > max_q) ? v : max_q;
          if (pop_data_i.set_end) begin
            k_d     = '0;
            state_d = sss_pkg::ST_SEEK;
          end
        end
      end
      sss_pkg::ST_SEEK: begin
        if (k_q + CntW'(1) == half) begin
          mid_hi_d = cell_q[0];
        end
        if (k_q == half) begin
          mid_lo_d = cell_q[0];
        end
        k_d = k_q + CntW'(1);
        if (k_last) begin
          k_d     = '0;
          state_d = sss_pkg::ST_STATS;
        end
      end
      sss_pkg::ST_STATS: begin
        if (div_rsp_i.done) begin
          avg_d   = div_rsp_i.quotient;
          med_d   = n_q[0] ? mid_lo_q : mid_sum[ValW:1];
          state_d = sss_pkg::ST_EMIT;
        end
      end
      sss_pkg::ST_EMIT: begin
        if (out_free) begin
          out_d.sorted_value = cell_q[0];
          out_d.last_out     = k_last;
          out_d.minimum      = min_q;
          out_d.maximum      = max_q;
          out_d.average      = avg_q;
          out_d.middle_value = med_q;
          out_valid_d        = 1'b1;
          k_d                = k_q + CntW'(1);
          if (k_last) begin
            k_d     = '0;
            n_d     = '0;
            sum_d   = '0;
            state_d = sss_pkg::ST_LOAD;
          end
        end
      end
      default: begin
        state_d = sss_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxItems; i++) begin
      cell_q[i] <= cell_d[i];
    end
    min_q    <= min_d;
    max_q    <= max_d;
    mid_hi_q <= mid_hi_d;
    mid_lo_q <= mid_lo_d;
    avg_q    <= avg_d;
    med_q    <= med_d;
    out_q    <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sss_pkg::ST_LOAD;
      n_q         <= '0;
      k_q         <= '0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      k_q         <= k_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire
